// File: rtl/dense_edge_pixel_suppressor_core_macros.svh
// Assertion macros shared by the dense edge pixel suppressor RTL.
`ifndef DENSE_EDGE_PIXEL_SUPPRESSOR_CORE_MACROS_SVH
`define DENSE_EDGE_PIXEL_SUPPRESSOR_CORE_MACROS_SVH

// Implication checked on every rising clock edge, quiet while reset is asserted.
`define DEPSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define DEPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/depsc_pkg.sv
// Package with the widths, register indexes and result type of the edge pixel suppressor.
package depsc_pkg;

	localparam int unsigned PIX_W       = 8;
	localparam int unsigned PIX_COL_W   = 10;
	localparam int unsigned PIX_ROW_W   = 16;
	localparam int unsigned LIMIT_W     = 4;
	localparam int unsigned FWIDTH_W    = 11;
	localparam int unsigned FHEIGHT_W   = 16;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned IN_DATA_W   = 8;
	localparam int unsigned OUT_DATA_W  = 40;
	localparam int unsigned CNT_W       = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOR_LIMIT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 4'd2;
	localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = 11'd640;
	localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 16'd480;

	// Neighbor mask of the 3x3 window: all bits but the center one.
	localparam logic [8:0] NEIGHBOR_MASK = 9'h1EF;

	// One result item as it waits in the output stage.
	typedef struct packed {
		logic                 run_last;
		logic [PIX_ROW_W-1:0] pixel_row;
		logic [PIX_COL_W-1:0] pixel_col;
		logic [PIX_W-1:0]     pixel_value;
	} res_t;

endpackage

// File: rtl/dense_edge_pixel_suppressor_core.sv
// Top level of the dense edge pixel suppressor: line buffer memory, window logic, output stage.
// A result is registered in stage one and then in the output stage before it is offered.
// One pixel per cycle while results are taken; a pixel with two results stalls stage one.
// Line buffer read at the transfer, written back when stage one moves on, with forwarding.
// Reset clears counters, window, center byte, configuration and valid flags at once.
// The line buffer memory is not cleared; entries are defined once the first rows are written.
`include "dense_edge_pixel_suppressor_core_macros.svh"

module dense_edge_pixel_suppressor_core #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_wen,
	input  logic [depsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [depsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Input pixel stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [depsc_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] edge_value
	// Output result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [depsc_pkg::OUT_DATA_W-1:0]    m_tdata,  // [7:0] pixel_value, [17:8] pixel_col,
	                                                      // [33:18] pixel_row, [39:34] zero
	output logic                                m_tlast   // run_last
);
	import depsc_pkg::*;

	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned WW = (CW + 1 > FWIDTH_W) ? CW + 1 : FWIDTH_W;
	localparam int unsigned MEM_W = PIX_W + 1;

	// Configuration registers.
	logic [LIMIT_W-1:0]   neighbor_limit_q;
	logic [FWIDTH_W-1:0]  frame_width_q;
	logic [FHEIGHT_W-1:0] frame_height_q;

	// Position counters of the next pixel.
	logic [CW-1:0]        col_q;
	logic [PIX_ROW_W-1:0] row_q;

	// Stage one registers.
	logic                 valid_s1;
	logic [PIX_W-1:0]     v_s1;
	logic [CW-1:0]        c_s1;
	logic [PIX_ROW_W-1:0] r_s1;
	logic                 border_s1;
	logic                 decide_s1;
	logic [MEM_W-1:0]     rd_s1;
	logic                 fwd_s1;
	logic [MEM_W-1:0]     fwd_data_s1;

	// Window state.
	logic [8:0]           window_q;
	logic [PIX_W-1:0]     center_q;

	// Output stage.
	logic                 out_valid_q;
	logic                 pend_q;
	res_t                 a_q;
	res_t                 b_q;

	// Line buffer: {older row active, prior row byte} per column.
	logic [MEM_W-1:0]     line_mem [MAX_WIDTH];

	logic                 accept;
	logic                 s1_adv;
	logic                 out_free;
	logic                 load;
	logic                 out_xfer;
	logic [WW-1:0]        fw_ext;
	logic [WW-1:0]        w_eff;
	logic [WW-1:0]        col_inc;
	logic [PIX_ROW_W:0]   h_eff;
	logic [PIX_ROW_W:0]   row_inc;
	logic                 last_col;
	logic                 last_row;
	logic                 border_s0;
	logic                 decide_s0;
	logic [MEM_W-1:0]     rd_data;
	logic                 top_bit;
	logic                 mid_bit;
	logic                 bot_bit;
	logic [8:0]           window_next;
	logic [CNT_W-1:0]     cnt;
	logic [PIX_W-1:0]     dec_value;
	logic [MEM_W-1:0]     wr_data;
	res_t                 dec_res;
	res_t                 bor_res;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neighbor_limit_q <= LIMIT_RESET;
			frame_width_q    <= FWIDTH_RESET;
			frame_height_q   <= FHEIGHT_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_NEIGHBOR_LIMIT: neighbor_limit_q <= cfg_wdata[LIMIT_W-1:0];
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_wdata[FWIDTH_W-1:0];
				REG_FRAME_HEIGHT:   frame_height_q   <= cfg_wdata[FHEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage one moves on when the output stage can take its results.
	assign out_free = !out_valid_q || (m_tready && !pend_q);
	assign s1_adv   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || s1_adv;
	assign accept   = s_tvalid && s_tready;
	assign out_xfer = out_valid_q && m_tready;

	// Effective geometry and position flags of the arriving pixel.
	always_comb begin
		fw_ext = WW'(frame_width_q);
		if (fw_ext == '0) begin
			w_eff = WW'(1);
		end else if (fw_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		h_eff     = (frame_height_q == '0) ? (PIX_ROW_W+1)'(1) : {1'b0, frame_height_q};
		col_inc   = WW'(col_q) + WW'(1);
		row_inc   = {1'b0, row_q} + (PIX_ROW_W+1)'(1);
		last_col  = col_inc >= w_eff;
		last_row  = row_inc >= h_eff;
		border_s0 = (row_q == '0) || (col_q == '0) || last_col || last_row;
		decide_s0 = (row_q >= PIX_ROW_W'(2)) && (col_q >= CW'(2));
	end

	// Position counters advance on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[PIX_ROW_W-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Stage one control, including the flag that forwards a same-column write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= s1_adv && (c_s1 == col_q);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1        <= s_tdata[PIX_W-1:0];
			c_s1        <= col_q;
			r_s1        <= row_q;
			border_s1   <= border_s0;
			decide_s1   <= decide_s0;
			fwd_data_s1 <= wr_data;
		end
	end

	// Line buffer: read at the input transfer, written back when stage one moves on.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			line_mem[c_s1] <= wr_data;
		end
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
	end

	// Window shift, neighbor count and decision for the pixel one row and column back.
	always_comb begin
		rd_data     = fwd_s1 ? fwd_data_s1 : rd_s1;
		top_bit     = rd_data[PIX_W];
		mid_bit     = |rd_data[PIX_W-1:0];
		bot_bit     = |v_s1;
		window_next = {window_q[5:0], top_bit, mid_bit, bot_bit};
		cnt         = CNT_W'($countones(window_next & NEIGHBOR_MASK));
		dec_value   = center_q;
		if ((center_q != '0) && (cnt > neighbor_limit_q)) begin
			dec_value = '0;
		end
		wr_data = {mid_bit, v_s1};

		dec_res.pixel_value = dec_value;
		dec_res.pixel_col   = PIX_COL_W'(c_s1 - CW'(1));
		dec_res.pixel_row   = r_s1 - PIX_ROW_W'(1);
		dec_res.run_last    = !border_s1;

		bor_res.pixel_value = v_s1;
		bor_res.pixel_col   = PIX_COL_W'(c_s1);
		bor_res.pixel_row   = r_s1;
		bor_res.run_last    = 1'b1;
	end

	// Window and center byte follow the items in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			center_q <= '0;
		end else if (s1_adv) begin
			window_q <= window_next;
			center_q <= rd_data[PIX_W-1:0];
		end
	end

	// Output stage control: a shown result and at most one pending behind it.
	assign load = s1_adv && (decide_s1 || border_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			pend_q      <= decide_s1 && border_s1;
		end else if (out_xfer) begin
			if (pend_q) begin
				pend_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= decide_s1 ? dec_res : bor_res;
			b_q <= bor_res;
		end else if (out_xfer && pend_q) begin
			a_q <= b_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = a_q.run_last;
	assign m_tdata  = {(OUT_DATA_W - PIX_W - PIX_COL_W - PIX_ROW_W)'(0),
	                   a_q.pixel_row, a_q.pixel_col, a_q.pixel_value};

	// Checks on the pipeline and output stage.
	`DEPSC_ASSERT_IMP(a_pend_needs_valid, pend_q, out_valid_q, "pending result without a shown one")
	`DEPSC_ASSERT_IMP(a_fwd_needs_s1, fwd_s1, valid_s1, "forward flag set with stage one empty")
	`DEPSC_ASSERT_IMP(a_ready_when_empty, !valid_s1, s_tready, "input stalled with stage one empty")
	`DEPSC_ASSERT_NEXT(a_run_continues, m_tvalid && m_tready && !m_tlast, m_tvalid, "run cut short")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the dense edge pixel suppressor core.
`timescale 1ns / 100ps

module testbench;
	import depsc_pkg::*;

	localparam int unsigned LINE_MAX      = 1024;
	localparam int unsigned RANDOM_PIXELS = 100;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES   = 300;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_wen   = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;  // [7:0] edge_value
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;         // [7:0] value, [17:8] col, [33:18] row
	logic                   m_tlast;         // run_last

	// Shadow of the configuration registers.
	logic [LIMIT_W-1:0]   limit_reg  = LIMIT_RESET;
	logic [FWIDTH_W-1:0]  width_reg  = FWIDTH_RESET;
	logic [FHEIGHT_W-1:0] height_reg = FHEIGHT_RESET;

	// Shadow of the filter state.
	logic [PIX_W-1:0]     line_bytes [LINE_MAX];
	logic                 older_active [LINE_MAX];
	logic [8:0]           window_bits = '0;
	logic [PIX_W-1:0]     center_byte = '0;
	logic [PIX_ROW_W-1:0] row_pos = '0;
	logic [PIX_COL_W-1:0] col_pos = '0;

	res_t        pending_pixels [$];
	int unsigned error_count = 0;
	int unsigned pixels_sent = 0;
	bit          steady_flow = 1'b0;
	int unsigned hold_len = 0;

	dense_edge_pixel_suppressor_core #(
		.MAX_WIDTH(LINE_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > LINE_MAX)
			return LINE_MAX;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : 32'(height_reg);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	// Append one expected result behind the others.
	task automatic queue_result(input res_t item);
		pending_pixels = {pending_pixels, item};
	endtask

	// Advance the filter shadow by one pixel and queue the results it causes.
	task automatic filter_pixel(input logic [PIX_W-1:0] v);
		int unsigned w, h, r, c;
		logic top, mid, bot, last_col, last_row, border;
		logic [PIX_W-1:0] prev;
		res_t res;
		w = eff_width();
		h = eff_height();
		r = 32'(row_pos);
		c = 32'(col_pos);
		prev = line_bytes[col_pos];
		top = older_active[col_pos];
		mid = (prev != 0);
		bot = (v != 0);
		last_col = (c + 1 >= w);
		last_row = (r + 1 >= h);
		border = (r == 0) || (c == 0) || last_col || last_row;
		window_bits = {window_bits[5:0], top, mid, bot};
		// The interior pixel one row up and one column left is decided first.
		if (r >= 2 && c >= 2) begin
			res.pixel_value = center_byte;
			if (center_byte != 0 && $countones(window_bits & NEIGHBOR_MASK) > limit_reg)
				res.pixel_value = '0;
			res.pixel_col = PIX_COL_W'(c - 1);
			res.pixel_row = PIX_ROW_W'(r - 1);
			res.run_last = !border;
			queue_result(res);
		end
		if (border) begin
			res.pixel_value = v;
			res.pixel_col = PIX_COL_W'(c);
			res.pixel_row = PIX_ROW_W'(r);
			res.run_last = 1'b1;
			queue_result(res);
		end
		center_byte = prev;
		older_active[col_pos] = mid;
		line_bytes[col_pos] = v;
		if (last_col) begin
			col_pos = '0;
			row_pos = last_row ? '0 : PIX_ROW_W'(r + 1);
		end else begin
			col_pos = PIX_COL_W'(c + 1);
		end
	endtask

	// Predict on every input transfer.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			filter_pixel(s_tdata);
	end

	// Compare every output transfer with the oldest prediction.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result, data %h last %b", m_tdata, m_tlast));
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[0 +: PIX_W] !== want.pixel_value)
					report_mismatch($sformatf("pixel_value (%0d,%0d): got %0d, expected %0d",
						want.pixel_row, want.pixel_col, m_tdata[0 +: PIX_W], want.pixel_value));
				if (m_tdata[PIX_W +: PIX_COL_W] !== want.pixel_col)
					report_mismatch($sformatf("pixel_col: got %0d, expected %0d",
						m_tdata[PIX_W +: PIX_COL_W], want.pixel_col));
				if (m_tdata[PIX_W+PIX_COL_W +: PIX_ROW_W] !== want.pixel_row)
					report_mismatch($sformatf("pixel_row: got %0d, expected %0d",
						m_tdata[PIX_W+PIX_COL_W +: PIX_ROW_W], want.pixel_row));
				if (m_tlast !== want.run_last)
					report_mismatch($sformatf("run_last (%0d,%0d): got %b, expected %b",
						want.pixel_row, want.pixel_col, m_tlast, want.run_last));
			end
		end
	end

	// Result receiver: random stalls, and one long hold-off when requested.
	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 6);
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// End the run when no transfer happens for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	// Offer one pixel after a random gap and hold it until the transfer.
	task automatic send_pixel(input logic [PIX_W-1:0] val);
		int unsigned gap;
		gap = steady_flow ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		pixels_sent++;
	endtask

	function automatic logic [PIX_W-1:0] random_pixel(input int unsigned density);
		if ($urandom_range(0, 99) < density) begin
			case ($urandom_range(0, 3))
				0: return 8'hFF;
				1: return 8'h01;
				default: return PIX_W'($urandom_range(1, 255));
			endcase
		end
		return 8'h00;
	endfunction

	// Send whole rows at the current width; the position is at a row start.
	task automatic send_rows(input int unsigned rows, input int unsigned density);
		repeat (rows) begin
			repeat (eff_width()) send_pixel(random_pixel(density));
		end
	endtask

	// Stop offering and wait until the block has nothing left in flight.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_NEIGHBOR_LIMIT: limit_reg = data[LIMIT_W-1:0];
			REG_FRAME_WIDTH:    width_reg = data[FWIDTH_W-1:0];
			REG_FRAME_HEIGHT:   height_reg = data[FHEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [CFG_DATA_W-1:0] limit,
		input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] height);
		wait_drain();
		cfg_write(REG_NEIGHBOR_LIMIT, limit);
		cfg_write(REG_FRAME_WIDTH, width);
		cfg_write(REG_FRAME_HEIGHT, height);
	endtask

	// Zero width and height act as one: every pixel is a lone border pixel.
	task automatic test_tiny_frames();
		set_geometry(16'd3, 16'd0, 16'd0);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h5A);
	endtask

	// All eight neighbors active, but a limit of eight never suppresses.
	task automatic test_large_limit();
		set_geometry(16'hFFF8, 16'd3, 16'd3);
		send_pixel(8'hFF); send_pixel(8'h80); send_pixel(8'h01);
		send_pixel(8'h7F); send_pixel(8'hA5); send_pixel(8'h5A);
		send_pixel(8'h02); send_pixel(8'hFE); send_pixel(8'h40);
	endtask

	// Shrink the width mid-row: the column counter wraps after the next pixel.
	task automatic test_mid_frame_geometry();
		set_geometry(16'd0, 16'd1024, 16'd3);
		send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h01);
		send_pixel(8'h80); send_pixel(8'h7F);
		wait_drain();
		cfg_write(REG_FRAME_WIDTH, 16'd3);
		send_pixel(8'h10);
		send_pixel(8'h00); send_pixel(8'hC3); send_pixel(8'h20);
		send_pixel(8'h40); send_pixel(8'h00); send_pixel(8'h08);
	endtask

	// One row at a width beyond the line buffer, which acts as the maximum.
	task automatic test_wide_row();
		set_geometry(16'd4, 16'hFFFF, 16'd1);
		send_rows(1, 30);
	endtask

	// Tallest frame setting, ended early by lowering the height at a row start.
	task automatic test_tall_frame();
		set_geometry(16'd15, 16'd5, 16'hFFFF);
		send_rows(6, 50);
		wait_drain();
		cfg_write(REG_FRAME_HEIGHT, 16'd1);
		send_rows(1, 50);
	endtask

	// Back-to-back transfers on both sides.
	task automatic test_steady_stream();
		set_geometry(16'd2, 16'd7, 16'd5);
		steady_flow = 1'b1;
		send_rows(10, 60);
		steady_flow = 1'b0;
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_output_backpressure();
		set_geometry(16'd3, 16'd8, 16'd10);
		steady_flow = 1'b1;
		hold_len = HOLD_CYCLES;
		send_rows(10, 50);
		steady_flow = 1'b0;
	endtask

	// Random whole frames under random settings, mostly small.
	task automatic test_random_frames();
		int unsigned start, limit, width, height;
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			limit = $urandom_range(0, 9);
			if (limit == 9)
				limit = 15;
			case ($urandom_range(0, 9))
				0: width = 0;
				1: width = 1;
				2: width = 2;
				default: width = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0: height = 0;
				1: height = 1;
				2: height = 2;
				default: height = $urandom_range(3, 8);
			endcase
			set_geometry(CFG_DATA_W'(limit), CFG_DATA_W'(width), CFG_DATA_W'(height));
			repeat ($urandom_range(1, 3)) send_rows(eff_height(), $urandom_range(0, 100));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_tiny_frames();
		test_large_limit();
		test_mid_frame_geometry();
		test_wide_row();
		test_tall_frame();
		test_steady_stream();
		test_output_backpressure();
		test_random_frames();
		wait_drain();
		repeat (10) @(negedge clk);
		if (pending_pixels.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/depsc_pkg.sv
rtl/dense_edge_pixel_suppressor_core.sv
verif/testbench.sv
